### hdl/four_ary_max_heap_queue_top_defines.svh
// ----------------------------------------------------------------------------
// four_ary_max_heap_queue_top_defines
// Assertion macros shared by the heap checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_ARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define FOUR_ARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define HQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/hq_pkg.sv
// ----------------------------------------------------------------------------
// hq_pkg
// Types and constants for the d-ary max heap queue.
// ----------------------------------------------------------------------------
package hq_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int ARITY_DEF    = 4;
	localparam int CNT_W        = 11;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_APPEND  = 2'd2;
	localparam logic [1:0] OP_BUILD   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] value;
	} hq_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] max_value;
		logic [CNT_W-1:0]   entry_total;
	} hq_out_t;

	// memory request from the sequencer
	typedef struct packed {
		logic        we;
		logic [15:0] addr;
		logic [31:0] wdata;
	} hq_mem_req_t;
endpackage

### hdl/hq_ram.sv
// ----------------------------------------------------------------------------
// hq_ram
// Single-port heap store with registered read.
// ----------------------------------------------------------------------------
module hq_ram import hq_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic        clk,
	input  hq_mem_req_t req,
	output logic [31:0] rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		rdata <= mem[req.addr[AW-1:0]];
	end
endmodule

### hdl/hq_seq.sv
// ----------------------------------------------------------------------------
// hq_seq
// Sequencer: walks sift-up, sift-down and build over the heap store.
// ----------------------------------------------------------------------------
module hq_seq import hq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int ARITY    = ARITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  hq_in_t      in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output hq_out_t     out_data,
	output hq_mem_req_t req,
	input  logic [31:0] rdata
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_UP_RD  = 4'd1;
	localparam logic [3:0] S_UP_CMP = 4'd2;
	localparam logic [3:0] S_UP_WR  = 4'd3;
	localparam logic [3:0] S_EX_RD0 = 4'd4;
	localparam logic [3:0] S_EX_RDL = 4'd5;
	localparam logic [3:0] S_EX_WR0 = 4'd6;
	localparam logic [3:0] S_DN_RDN = 4'd7;
	localparam logic [3:0] S_DN_RDC = 4'd8;
	localparam logic [3:0] S_DN_CMP = 4'd9;
	localparam logic [3:0] S_DN_WR  = 4'd10;
	localparam logic [3:0] S_BLD    = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;
	localparam logic [3:0] S_DN_LST = 4'd13;
	localparam int AB = $clog2(ARITY) + 1;
	// reciprocal for an exact divide by ARITY of any 17-bit value
	localparam int DSH = 17 + $clog2(ARITY);
	localparam logic [39:0] DMUL =
		40'(((64'd1 << DSH) + 64'(ARITY) - 64'd1) / 64'(ARITY));

	logic [3:0]        state_q;
	logic [16:0]       count_q;
	logic [16:0]       node_q, best_q, child_q, bld_q;
	logic              other_q;
	logic [AB-1:0]     cidx_q;
	logic [31:0]       nval_q, bval_q, ext_q;
	logic              build_q, cvalid_q;
	logic [1:0]        status_q;
	hq_mem_req_t       req_d;
	logic              out_full_q;
	hq_out_t           out_q;
	logic [16:0]       parent_w;
	logic [19:0]       first_w;

	function automatic logic [16:0] div_arity(input logic [16:0] x);
		logic [39:0] prod;
		prod = 40'(x) * DMUL;
		return prod[DSH +: 17];
	endfunction

	// (node-1)/ARITY by reciprocal multiply
	assign parent_w = div_arity(node_q - 17'd1);
	assign first_w  = 20'(node_q) * 20'(ARITY) + 20'd1;

	assign in_stall  = (state_q != S_IDLE) || out_full_q;
	assign out_valid = out_full_q;
	assign out_data  = out_q;
	assign req       = req_d;

	always_comb begin
		req_d = '0;
		case (state_q)
			S_UP_RD:  req_d.addr = 16'(parent_w);
			// parent moves down into the hole while the key climbs
			S_UP_CMP: begin
				if ($signed(nval_q) > $signed(rdata)) begin
					req_d.we = 1'b1; req_d.addr = 16'(node_q); req_d.wdata = rdata;
				end
			end
			S_UP_WR:  begin
				req_d.we = 1'b1; req_d.addr = 16'(node_q); req_d.wdata = bval_q;
			end
			S_EX_RD0: req_d.addr = 16'd0;
			S_EX_RDL: req_d.addr = 16'(count_q - 17'd1);
			S_EX_WR0: begin
				req_d.we = 1'b1; req_d.addr = 16'd0; req_d.wdata = rdata;
			end
			S_DN_RDN: req_d.addr = 16'(node_q);
			S_DN_RDC: req_d.addr = 16'(child_q);
			S_DN_WR:  begin
				req_d.we = 1'b1; req_d.addr = 16'(node_q); req_d.wdata = bval_q;
			end
			S_DN_LST: begin
				req_d.we = 1'b1; req_d.addr = 16'(best_q); req_d.wdata = nval_q;
			end
			default:  req_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (out_full_q && !out_stall) out_full_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						ext_q <= '0;
						case (in_data.operation)
							OP_INSERT, OP_APPEND: begin
								if (count_q >= 17'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									node_q   <= count_q;
									nval_q   <= in_data.value;
									bval_q   <= in_data.value;
									count_q  <= count_q + 17'd1;
									// append: plain write via S_UP_WR with no climb
									other_q  <= (in_data.operation == OP_INSERT);
									state_q  <= S_UP_WR;
								end
							end
							OP_EXTRACT: begin
								build_q <= 1'b0;
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									status_q <= ST_OK;
									state_q  <= S_EX_RD0;
								end
							end
							default: begin
								status_q <= ST_OK;
								if (count_q > 17'd1) begin
									build_q <= 1'b1;
									bld_q   <= div_arity(count_q - 17'd2) + 17'd1;
									state_q <= S_BLD;
								end else begin
									state_q <= S_DONE;
								end
							end
						endcase
					end
				end
				// write key at node; if climbing continue upward
				S_UP_WR: begin
					if (other_q && node_q != '0) state_q <= S_UP_RD;
					else state_q <= S_DONE;
				end
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if ($signed(nval_q) > $signed(rdata)) begin
						node_q  <= parent_w;
						state_q <= S_UP_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EX_RD0: state_q <= S_EX_RDL;
				S_EX_RDL: begin
					ext_q   <= rdata;
					state_q <= S_EX_WR0;
				end
				S_EX_WR0: begin
					count_q <= count_q - 17'd1;
					node_q  <= '0;
					state_q <= S_DN_RDN;
				end
				S_BLD: begin
					if (bld_q == '0) begin
						state_q <= S_DONE;
					end else begin
						node_q  <= bld_q - 17'd1;
						bld_q   <= bld_q - 17'd1;
						state_q <= S_DN_RDN;
					end
				end
				S_DN_RDN: begin
					if (first_w >= 20'(count_q)) begin
						state_q <= build_q ? S_BLD : S_DONE;
					end else begin
						child_q  <= 17'(first_w);
						cidx_q   <= '0;
						cvalid_q <= 1'b0;
						state_q  <= S_DN_RDC;
					end
				end
				S_DN_RDC: begin
					if (!cvalid_q) begin
						nval_q   <= rdata;
						cvalid_q <= 1'b1;
					end else if (cidx_q == AB'(1) || $signed(rdata) > $signed(bval_q)) begin
						bval_q <= rdata;
						best_q <= child_q - 17'd1;
					end
					if (cvalid_q) cidx_q <= cidx_q + AB'(1);
					if (cvalid_q && (cidx_q == AB'(ARITY) || child_q >= count_q)) begin
						state_q <= S_DN_CMP;
					end else if (cvalid_q) begin
						child_q <= child_q + 17'd1;
					end
					if (!cvalid_q) begin
						cidx_q <= AB'(1);
						child_q <= child_q + 17'd1;
					end
				end
				S_DN_CMP: begin
					if ($signed(nval_q) >= $signed(bval_q)) state_q <= build_q ? S_BLD : S_DONE;
					else state_q <= S_DN_WR;
				end
				S_DN_WR:  state_q <= S_DN_LST;
				S_DN_LST: begin
					node_q  <= best_q;
					state_q <= S_DN_RDN;
				end
				S_DONE: begin
					out_q.status      <= status_q;
					out_q.max_value   <= ext_q;
					out_q.entry_total <= CNT_W'(count_q);
					out_full_q        <= 1'b1;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hdl/four_ary_max_heap_queue_top.sv
// ----------------------------------------------------------------------------
// four_ary_max_heap_queue_top
// Max priority queue held as a d-ary heap in one synchronous memory.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one operation per beat:
// insert, extract max, append, build. Output channel out_valid/out_stall/
// out_data returns one result beat per operation with status, extracted key
// and entry count. One operation is in flight at a time; in_stall stays high
// while it walks the heap or while a result waits.
// Timing is set by the single memory port. Insert steps through each level
// climbed, extract through each level descended, and build runs one sift-down
// per internal node. Append writes the key with no climb; rejected operations
// and trivial builds go straight to the result.
// Reset empties the queue at once; memory contents are not cleared.
// A stalled result holds on out_data; no new operation starts until taken.
// ----------------------------------------------------------------------------
module four_ary_max_heap_queue_top import hq_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int ARITY    = ARITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  hq_in_t  in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output hq_out_t out_data
);
	hq_mem_req_t req;
	logic [31:0] rdata;

	hq_seq #(.CAPACITY(CAPACITY), .ARITY(ARITY)) u_seq (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data, .req, .rdata
	);

	hq_ram #(.DEPTH(CAPACITY)) u_ram (.clk, .req, .rdata);
endmodule

### hdl/hq_checker.sv
// ----------------------------------------------------------------------------
// hq_checker
// Port-level checks on the heap queue.
// ----------------------------------------------------------------------------
`include "four_ary_max_heap_queue_top_defines.svh"
module hq_checker import hq_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_stall,
	input hq_in_t  in_data,
	input logic    out_valid,
	input logic    out_stall,
	input hq_out_t out_data
);
	`HQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")
	`HQ_ASSERT_IMP(a_busy, clk, arst_n, out_valid, in_stall, "input taken while result pending")
	`HQ_ASSERT_IMP(a_zero, clk, arst_n, out_valid && out_data.status != ST_OK, out_data.max_value == 0, "nonzero key on failure")
	`HQ_ASSERT_IMP(a_cnt, clk, arst_n, out_valid, out_data.entry_total <= 11'd1024, "count out of range")
endmodule

bind four_ary_max_heap_queue_top hq_checker u_chk (.*);

### sim/tb_four_ary_max_heap_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_ary_max_heap_queue_top
// Checks the 4-ary max heap queue against a behavioral heap kept in the bench.
// The bench runs directed corner cases first. The random part fills and drains
// the heap, and includes a full heap, unordered appends followed by a build, and
// operations on an empty heap. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_four_ary_max_heap_queue_top;
	import hq_pkg::*;

	localparam int CAP      = CAPACITY_DEF;
	localparam int ARY      = ARITY_DEF;
	localparam int WDOG_MAX = 200000;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	hq_in_t  in_data;
	logic    out_valid;
	logic    out_stall;
	hq_out_t out_data;

	four_ary_max_heap_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	// behavioral heap
	logic signed [31:0] heap_mem [CAP];
	int                 heap_cnt = 0;

	hq_in_t  op_queue [$];
	hq_out_t result_queue [$];
	int      err_cnt = 0;
	int      wdog = 0;
	bit      quiet;      // no idling at end of run
	bit      hold_rx;    // long receiver hold-off request
	bit      hold_tx;    // sender pauses until drained
	int      tx_idle, rx_idle, hold_cnt;

	function automatic void swap_entries(int a, int b);
		logic signed [31:0] t;
		t = heap_mem[a];
		heap_mem[a] = heap_mem[b];
		heap_mem[b] = t;
	endfunction

	function automatic void heap_sink(int node, int cnt);
		int first, best;
		forever begin
			first = ARY * node + 1;
			if (first >= cnt) return;
			best = first;
			for (int j = 1; j < ARY; j++) begin
				if (first + j >= cnt) break;
				if (heap_mem[first + j] > heap_mem[best]) best = first + j;
			end
			if (heap_mem[node] >= heap_mem[best]) return;
			swap_entries(node, best);
			node = best;
		end
	endfunction

	function automatic hq_out_t heap_apply(hq_in_t op);
		hq_out_t r;
		int node, up;
		r = '0;
		r.status = ST_OK;
		case (op.operation)
			OP_INSERT, OP_APPEND: begin
				if (heap_cnt >= CAP) begin
					r.status = ST_FULL;
				end else begin
					heap_mem[heap_cnt] = op.value;
					heap_cnt++;
					if (op.operation == OP_INSERT) begin
						node = heap_cnt - 1;
						while (node > 0) begin
							up = (node - 1) / ARY;
							if (heap_mem[node] <= heap_mem[up]) break;
							swap_entries(node, up);
							node = up;
						end
					end
				end
			end
			OP_EXTRACT: begin
				if (heap_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.max_value = heap_mem[0];
					heap_mem[0] = heap_mem[heap_cnt - 1];
					heap_cnt--;
					heap_sink(0, heap_cnt);
				end
			end
			default: begin
				if (heap_cnt > 1)
					for (int i = (heap_cnt - 2) / ARY; i >= 0; i--) heap_sink(i, heap_cnt);
			end
		endcase
		r.entry_total = heap_cnt[CNT_W-1:0];
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			tx_idle  <= 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) result_queue.push_back(heap_apply(in_data));
			if (tx_idle > 0) begin
				in_valid <= 1'b0;
				tx_idle  <= tx_idle - 1;
			end else if (hold_tx && (result_queue.size() != 0 || in_valid)) begin
				in_valid <= 1'b0;
			end else if (op_queue.size() != 0) begin
				in_valid <= 1'b1;
				in_data  <= op_queue.pop_front();
				if (!quiet && !hold_rx && $urandom_range(0, 9) == 0)
					tx_idle <= $urandom_range(1, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_idle   <= 0;
			hold_cnt  <= 0;
		end else if (hold_rx && hold_cnt < 400) begin
			out_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else if (rx_idle > 0) begin
			out_stall <= 1'b1;
			rx_idle   <= rx_idle - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			rx_idle   <= $urandom_range(0, 12);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		hq_out_t exp_r;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog <= 0;
			else wdog <= wdog + 1;
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$error("result beat with nothing expected");
					err_cnt++;
				end else begin
					exp_r = result_queue.pop_front();
					if (out_data.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, out_data.status);
						err_cnt++;
					end
					if (out_data.max_value !== exp_r.max_value) begin
						$error("max_value: expected %0d, got %0d",
							exp_r.max_value, out_data.max_value);
						err_cnt++;
					end
					if (out_data.entry_total !== exp_r.entry_total) begin
						$error("entry_total: expected %0d, got %0d",
							exp_r.entry_total, out_data.entry_total);
						err_cnt++;
					end
				end
			end
			if (wdog >= WDOG_MAX) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 7)) - 3;
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic add_op(logic [1:0] op, logic signed [31:0] v);
		hq_in_t t;
		t.operation = op;
		t.value     = v;
		op_queue.push_back(t);
	endtask

	task automatic wait_drained();
		while (op_queue.size() != 0 || in_valid || result_queue.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n, mode, k;
		arst_n = 1'b0;
		quiet = 0; hold_rx = 0; hold_tx = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners
		add_op(OP_EXTRACT, 32'sd5);
		add_op(OP_BUILD, 32'sd0);
		add_op(OP_INSERT, 32'sh80000000);
		add_op(OP_BUILD, 32'sd0);
		add_op(OP_INSERT, 32'sh7FFFFFFF);
		add_op(OP_INSERT, -32'sd1);
		add_op(OP_INSERT, 32'sd0);
		add_op(OP_INSERT, 32'sd0);
		add_op(OP_APPEND, 32'sh55555555);
		add_op(OP_APPEND, 32'shAAAAAAAA);
		add_op(OP_APPEND, 32'sh7FFFFFFF);
		add_op(OP_BUILD, 32'sd0);
		for (int i = 0; i < 9; i++) add_op(OP_EXTRACT, $signed($urandom()));
		add_op(OP_APPEND, 32'sd3);
		add_op(OP_EXTRACT, 32'sd0);
		wait_drained();

		// fill to capacity with stalled receiver, then try to overflow
		hold_rx = 1;
		for (int i = 0; i < CAP; i++)
			add_op($urandom_range(0, 3) == 0 ? OP_APPEND : OP_INSERT, rand_key());
		add_op(OP_INSERT, 32'sd1);
		add_op(OP_APPEND, 32'sd2);
		add_op(OP_BUILD, 32'sd0);
		while (hold_cnt < 400) @(posedge clk);
		hold_rx = 0;
		wait_drained();
		// sender pause until drained
		hold_tx = 1;
		add_op(OP_EXTRACT, 32'sd0);
		add_op(OP_EXTRACT, 32'sd0);
		wait_drained();
		hold_tx = 0;
		// drain part of it
		for (int i = 0; i < 150; i++) add_op(OP_EXTRACT, 32'sd0);
		wait_drained();

		// random mix of operations
		n = 0;
		while (n < 75) begin
			mode = $urandom_range(0, 3);
			if (mode == 0) begin
				k = $urandom_range(2, 12);
				for (int i = 0; i < k; i++) add_op(OP_APPEND, rand_key());
				add_op(OP_BUILD, 32'sd0);
			end else if (mode == 1) begin
				k = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) add_op(OP_INSERT, rand_key());
			end else if (mode == 2) begin
				k = $urandom_range(1, 10);
				for (int i = 0; i < k; i++) add_op(OP_EXTRACT, rand_key());
			end else begin
				add_op(2'($urandom_range(0, 3)), rand_key());
			end
			n = n + 1;
			if (n == 60) begin
				wait_drained();
				quiet = 1;
			end
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
